FILE: rtl/jacobi_and_modular_inverse_unit_macros.svh
// assertion macros for the jacobi symbol and modular inverse unit
`ifndef JACOBI_AND_MODULAR_INVERSE_UNIT_MACROS_SVH
`define JACOBI_AND_MODULAR_INVERSE_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define JMI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define JMI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/jmi_pkg.sv
// shared types and constants for the jacobi symbol and modular inverse unit
`default_nettype none

package jmi_pkg;

	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);

	// opcodes
	localparam logic OP_JACOBI  = 1'b0;
	localparam logic OP_INVERSE = 1'b1;

	// status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO_MOD = 2'd1;
	localparam logic [1:0] STATUS_EVEN_MOD = 2'd2;
	localparam logic [1:0] STATUS_NO_INV   = 2'd3;

	// jacobi symbol codes, two's complement
	localparam logic signed [1:0] SYM_ZERO = 2'sb00;
	localparam logic signed [1:0] SYM_POS  = 2'sb01;
	localparam logic signed [1:0] SYM_NEG  = 2'sb11;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_RED_FIX,
		S_J_LOOP,
		S_J_DIV,
		S_I_LOOP,
		S_I_DIV,
		S_I_UPD
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/jacobi_and_modular_inverse_unit.sv
// Jacobi symbol / modular inverse unit with one shared bit-serial divider.
// Zero modulus, or even modulus for Jacobi: result strobed in the cycle after start. Otherwise
// the divider reduces the value, then Jacobi strips each factor of two in its own step or swaps
// and takes a remainder; inverse divides, then updates coefficients; strobe follows the loop.
// Busy holds off start for the whole transaction, one at a time; the receiver cannot stall.
// Reset clears the sequencer and the done strobe.
`default_nettype none

`include "jacobi_and_modular_inverse_unit_macros.svh"

module jacobi_and_modular_inverse_unit
	import jmi_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    opcode,
	input  wire logic signed [WIDTH-1:0] value,
	input  wire logic        [WIDTH-1:0] modulus,
	output logic                         done,
	output logic signed [1:0]            symbol,
	output logic        [WIDTH-1:0]      inverse,
	output logic        [1:0]            status
);

	state_t state_q, state_d;

	logic             opcode_q;
	logic             neg_q;
	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] r0_q, r1_q;
	logic [WIDTH-1:0] c0_q, c1_q;
	logic             n0_q, n1_q;
	logic             sgn_q;
	logic [WIDTH-1:0] dsr_q, dvd_q, rem_q, prod_q;
	logic [CNT_W-1:0] cnt_q;

	logic                    done_q;
	logic signed [1:0]       symbol_q;
	logic        [WIDTH-1:0] inverse_q;
	logic        [1:0]       status_q;

	// finishing transaction from the sequencer
	logic                    fin;
	logic signed [1:0]       fin_sym;
	logic        [WIDTH-1:0] fin_inv;
	logic        [1:0]       fin_st;

	// shared restoring divider step, plus shift-add of quotient times c1
	logic [WIDTH:0]   shifted, diff;
	logic             qbit;
	logic [WIDTH-1:0] rem_nxt, dvd_nxt, prod_nxt;
	logic             div_last;

	assign shifted  = {rem_q, dvd_q[WIDTH-1]};
	assign diff     = shifted - {1'b0, dsr_q};
	assign qbit     = ~diff[WIDTH];
	assign rem_nxt  = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
	assign dvd_nxt  = {dvd_q[WIDTH-2:0], qbit};
	assign prod_nxt = {prod_q[WIDTH-2:0], 1'b0} + (qbit ? c1_q : '0);
	assign div_last = (cnt_q == CNT_W'(WIDTH - 1));

	// magnitude of the signed operand
	logic [WIDTH-1:0] mag;
	assign mag = value[WIDTH-1] ? (~value + 1'b1) : value;

	// true residue from the remainder of the magnitude
	logic [WIDTH-1:0] red_val;
	assign red_val = (neg_q && (rem_q != '0)) ? (m_q - rem_q) : rem_q;

	// jacobi sign flips
	logic flip_two, flip_recip;
	assign flip_two   = (r0_q[2:0] == 3'd3) || (r0_q[2:0] == 3'd5);
	assign flip_recip = (r0_q[1:0] == 2'd3) && (r1_q[1:0] == 2'd3);

	// coefficient normalized into 0..m-1 with its sign applied
	logic [WIDTH-1:0] c_mod, inv_val;
	assign c_mod   = (c0_q == m_q) ? '0 : c0_q;
	assign inv_val = (n0_q && (c_mod != '0)) ? (m_q - c_mod) : c_mod;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and finishing results
	always_comb begin
		state_d = state_q;
		fin     = 1'b0;
		fin_sym = SYM_ZERO;
		fin_inv = '0;
		fin_st  = STATUS_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (modulus == '0) begin
						fin    = 1'b1;
						fin_st = STATUS_ZERO_MOD;
					end else if ((opcode == OP_JACOBI) && !modulus[0]) begin
						fin    = 1'b1;
						fin_st = STATUS_EVEN_MOD;
					end else begin
						state_d = S_RED;
					end
				end
			end
			S_RED: begin
				if (div_last) begin
					state_d = S_RED_FIX;
				end
			end
			S_RED_FIX: begin
				state_d = S_I_LOOP;
				if (opcode_q == OP_JACOBI) begin
					state_d = S_J_LOOP;
				end
			end
			S_J_LOOP: begin
				if (r1_q == '0) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (r0_q == WIDTH'(1)) begin
						fin_sym = sgn_q ? SYM_NEG : SYM_POS;
					end
				end else if (r1_q[0]) begin
					state_d = S_J_DIV;
				end
			end
			S_J_DIV: begin
				if (div_last) begin
					state_d = S_J_LOOP;
				end
			end
			S_I_LOOP: begin
				if (r1_q == '0) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (r0_q == WIDTH'(1)) begin
						fin_inv = inv_val;
					end else begin
						fin_st = STATUS_NO_INV;
					end
				end else begin
					state_d = S_I_DIV;
				end
			end
			S_I_DIV: begin
				if (div_last) begin
					state_d = S_I_UPD;
				end
			end
			S_I_UPD: begin
				state_d = S_I_LOOP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					opcode_q <= opcode;
					neg_q    <= value[WIDTH-1];
					m_q      <= modulus;
					dsr_q    <= modulus;
					dvd_q    <= mag;
					rem_q    <= '0;
					cnt_q    <= '0;
				end
			end
			S_RED: begin
				rem_q <= rem_nxt;
				dvd_q <= dvd_nxt;
				cnt_q <= cnt_q + 1'b1;
			end
			S_RED_FIX: begin
				r0_q  <= m_q;
				r1_q  <= red_val;
				c0_q  <= '0;
				c1_q  <= WIDTH'(1);
				n0_q  <= 1'b0;
				n1_q  <= 1'b0;
				sgn_q <= 1'b0;
			end
			S_J_LOOP: begin
				if (r1_q != '0) begin
					if (!r1_q[0]) begin
						// remove one factor of two
						r1_q <= r1_q >> 1;
						if (flip_two) begin
							sgn_q <= ~sgn_q;
						end
					end else begin
						// swap and start the remainder
						r0_q  <= r1_q;
						dsr_q <= r1_q;
						dvd_q <= r0_q;
						rem_q <= '0;
						cnt_q <= '0;
						if (flip_recip) begin
							sgn_q <= ~sgn_q;
						end
					end
				end
			end
			S_J_DIV: begin
				rem_q <= rem_nxt;
				dvd_q <= dvd_nxt;
				cnt_q <= cnt_q + 1'b1;
				if (div_last) begin
					r1_q <= rem_nxt;
				end
			end
			S_I_LOOP: begin
				if (r1_q != '0) begin
					dsr_q  <= r1_q;
					dvd_q  <= r0_q;
					rem_q  <= '0;
					cnt_q  <= '0;
					prod_q <= '0;
				end
			end
			S_I_DIV: begin
				rem_q  <= rem_nxt;
				dvd_q  <= dvd_nxt;
				prod_q <= prod_nxt;
				cnt_q  <= cnt_q + 1'b1;
				if (div_last) begin
					r0_q <= r1_q;
					r1_q <= rem_nxt;
				end
			end
			S_I_UPD: begin
				// coefficient signs alternate, so magnitudes add
				c0_q <= c1_q;
				n0_q <= n1_q;
				c1_q <= c0_q + prod_q;
				n1_q <= ~n1_q;
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fin) begin
			symbol_q  <= fin_sym;
			inverse_q <= fin_inv;
			status_q  <= fin_st;
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign symbol  = symbol_q;
	assign inverse = inverse_q;
	assign status  = status_q;

	// checks
	`JMI_ASSERT_NOW(a_no_done_while_busy, busy, !done,
		"result strobed while the sequencer is still running")
	`JMI_ASSERT_NEXT(a_start_progress, start && !busy, busy || done,
		"accepted transaction neither started nor finished")
	`JMI_ASSERT_NOW(a_error_fields_zero, done && (status != STATUS_OK),
		(symbol == SYM_ZERO) && (inverse == '0),
		"error result carries nonzero fields")
	`JMI_ASSERT_NOW(a_one_field_used, done && (symbol != SYM_ZERO), inverse == '0,
		"jacobi result carries an inverse")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// testbench for the jacobi symbol and modular inverse unit
`timescale 1ns / 1ps

module tb
	import jmi_pkg::*;
();

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    opcode = OP_JACOBI;
	logic signed [WIDTH-1:0] value = '0;
	logic        [WIDTH-1:0] modulus = '0;
	logic                    busy;
	logic                    done;
	logic signed [1:0]       symbol;
	logic        [WIDTH-1:0] inverse;
	logic        [1:0]       status;

	typedef struct packed {
		logic signed [1:0]  sym;
		logic [WIDTH-1:0]   inv;
		logic [1:0]         st;
	} answer_t;

	// expected answers of the number-theory operations, in order of acceptance
	class residue_scoreboard;
		answer_t owed[$];
		int mismatches = 0;
		int jacobi_cnt = 0;
		int inverse_cnt = 0;
		int error_cnt = 0;
		int checked = 0;

		task report_mismatch(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			mismatches++;
		endtask

		// true residue of the signed operand modulo n
		function logic [63:0] residue(logic signed [WIDTH-1:0] a, logic [63:0] n);
			logic [63:0] wide;
			logic [63:0] r;
			wide = {{(64-WIDTH){a[WIDTH-1]}}, a};
			if (a[WIDTH-1]) begin
				r = (~wide + 64'd1) % n;
				return (r != 64'd0) ? n - r : 64'd0;
			end
			return wide % n;
		endfunction

		// binary jacobi symbol, n odd, a reduced
		function int jacobi_of(logic [63:0] a, logic [63:0] n);
			logic [63:0] t;
			int s;
			s = 1;
			while (a != 64'd0) begin
				while (a[0] == 1'b0) begin
					a = a >> 1;
					if (n[2:0] == 3'd3 || n[2:0] == 3'd5)
						s = -s;
				end
				t = a;
				a = n;
				n = t;
				if (a[1:0] == 2'd3 && n[1:0] == 2'd3)
					s = -s;
				a = a % n;
			end
			return (n == 64'd1) ? s : 0;
		endfunction

		// extended euclid with coefficient magnitudes and signs
		function bit inverse_mod(logic [63:0] a, logic [63:0] m, output logic [63:0] inv);
			logic [63:0] r0, r1, r2, c0, c1, c2, q;
			bit n0, n1, n2;
			r0 = m;
			r1 = a;
			c0 = 64'd0;
			c1 = 64'd1;
			n0 = 1'b0;
			n1 = 1'b0;
			inv = 64'd0;
			while (r1 != 64'd0) begin
				q = r0 / r1;
				r2 = r0 - q * r1;
				c2 = c0 + q * c1;
				n2 = !n1;
				r0 = r1;
				r1 = r2;
				c0 = c1;
				n0 = n1;
				c1 = c2;
				n1 = n2;
			end
			if (r0 != 64'd1)
				return 1'b0;
			c0 = c0 % m;
			inv = (n0 && c0 != 64'd0) ? m - c0 : c0;
			return 1'b1;
		endfunction

		// accepted transaction: work out its answer
		function void note_request(logic op, logic signed [WIDTH-1:0] a, logic [WIDTH-1:0] n);
			answer_t ans;
			logic [63:0] n64;
			logic [63:0] x;
			int s;
			ans.sym = SYM_ZERO;
			ans.inv = '0;
			ans.st = STATUS_OK;
			n64 = {{(64-WIDTH){1'b0}}, n};
			if (n64 == 64'd0) begin
				ans.st = STATUS_ZERO_MOD;
			end else if (op == OP_JACOBI) begin
				if (n64[0] == 1'b0) begin
					ans.st = STATUS_EVEN_MOD;
				end else begin
					s = jacobi_of(residue(a, n64), n64);
					ans.sym = (s < 0) ? SYM_NEG : (s > 0) ? SYM_POS : SYM_ZERO;
				end
			end else begin
				if (inverse_mod(residue(a, n64), n64, x))
					ans.inv = x[WIDTH-1:0];
				else
					ans.st = STATUS_NO_INV;
			end
			if (op == OP_JACOBI)
				jacobi_cnt++;
			else
				inverse_cnt++;
			if (ans.st != STATUS_OK)
				error_cnt++;
			owed.insert(owed.size(), ans);
		endfunction

		// strobed result against the oldest expected answer
		task check_result(logic signed [1:0] sym, logic [WIDTH-1:0] inv, logic [1:0] st);
			answer_t ans;
			if (owed.size() == 0) begin
				report_mismatch("result strobed with no transaction outstanding");
				return;
			end
			ans = owed[0];
			owed.delete(0);
			checked++;
			if (sym !== ans.sym)
				report_mismatch($sformatf("symbol %0d, expected %0d", sym, ans.sym));
			if (inv !== ans.inv)
				report_mismatch($sformatf("inverse %0h, expected %0h", inv, ans.inv));
			if (st !== ans.st)
				report_mismatch($sformatf("status %0d, expected %0d", st, ans.st));
		endtask
	endclass

	residue_scoreboard board = new();

	jacobi_and_modular_inverse_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.value(value),
		.modulus(modulus),
		.done(done),
		.symbol(symbol),
		.inverse(inverse),
		.status(status)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// sample handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_result(symbol, inverse, status);
			if (start && !busy)
				board.note_request(opcode, value, modulus);
		end
	end

	// present one transaction at a falling edge and hold it until accepted
	task automatic send_request(input logic op, input logic signed [WIDTH-1:0] a,
			input logic [WIDTH-1:0] n, input int idle_pct);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 5);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		value <= a;
		modulus <= n;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random transaction, biased toward the interesting operand shapes
	task automatic random_request(input int idle_pct);
		logic op;
		logic signed [WIDTH-1:0] a;
		logic [WIDTH-1:0] n;
		int f;
		int k;
		op = 1'($urandom_range(0, 1));
		a = $urandom;
		n = $urandom | 32'd1;
		case ($urandom_range(0, 19))
			0: n = '0;
			1, 2, 3: n = $urandom_range(1, 64);
			4, 5: n = $urandom & ~32'd1;
			6, 7, 8: begin
				// operands sharing an odd factor
				f = $urandom_range(1, 49) * 2 + 1;
				k = $urandom_range(0, 100000);
				n = f * ($urandom_range(0, 9999) * 2 + 1);
				a = f * k;
				if ($urandom_range(0, 1))
					a = -a;
			end
			9: a = $signed($urandom_range(0, 16)) - 8;
			default: ;
		endcase
		send_request(op, a, n, idle_pct);
	endtask

	initial begin
		int idle_pct;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners
		send_request(OP_JACOBI, 32'sd5, 32'd0, 0);
		send_request(OP_INVERSE, 32'sd5, 32'd0, 0);
		send_request(OP_JACOBI, 32'sd3, 32'd2, 0);
		send_request(OP_JACOBI, 32'sh7fff_ffff, 32'hffff_fffe, 0);
		send_request(OP_INVERSE, 32'sd3, 32'd8, 0);
		send_request(OP_JACOBI, 32'sh8000_0000, 32'd1, 0);
		send_request(OP_INVERSE, 32'sh7fff_ffff, 32'd1, 0);
		send_request(OP_JACOBI, 32'sd15, 32'd21, 0);
		send_request(OP_INVERSE, 32'sd6, 32'd9, 0);
		send_request(OP_INVERSE, 32'sd0, 32'd7, 0);
		send_request(OP_JACOBI, 32'sd0, 32'd7, 0);
		send_request(OP_JACOBI, 32'sh8000_0000, 32'hffff_ffff, 0);
		send_request(OP_INVERSE, 32'sh8000_0000, 32'hffff_ffff, 0);
		send_request(OP_JACOBI, 32'sh7fff_ffff, 32'hffff_ffff, 0);
		send_request(OP_INVERSE, 32'sh7fff_ffff, 32'hffff_ffff, 0);
		send_request(OP_INVERSE, -32'sd1, 32'd3, 0);
		send_request(OP_JACOBI, -32'sd1, 32'd7, 0);
		send_request(OP_JACOBI, 32'sd2, 32'd3, 0);
		send_request(OP_JACOBI, 32'sd2, 32'd7, 0);
		send_request(OP_JACOBI, 32'sd3, 32'd7, 0);
		send_request(OP_JACOBI, 32'sh4000_0000, 32'hffff_fffb, 0);
		// consecutive fibonacci numbers: longest euclid chain
		send_request(OP_INVERSE, 32'sd1836311903, 32'd2971215073, 0);
		send_request(OP_JACOBI, 32'sd1836311903, 32'd2971215073, 0);
		send_request(OP_INVERSE, -32'sd1836311903, 32'hffff_fffe, 0);

		// random phases: no idling, heavy sender idling, none again, light idling
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				1: idle_pct = 66;
				3: idle_pct = 28;
				default: idle_pct = 0;
			endcase
			repeat (470)
				random_request(idle_pct);
		end
		start <= 1'b0;

		// drain, then watch for stray strobes
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("covered %0d transactions: %0d jacobi, %0d inverse, %0d with error status",
			board.jacobi_cnt + board.inverse_cnt, board.jacobi_cnt, board.inverse_cnt,
			board.error_cnt);
		$display("%0d results checked, %0d mismatches", board.checked, board.mismatches);
		if (board.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#500_000_000;
		$display("timeout with %0d results outstanding", board.owed.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
